FILE: hdl/vfl_pkg.sv
package vfl_pkg;

    // build-time defaults for the top-level parameters
    localparam int MAX_FRAMES_DEF       = 128;
    localparam int MAX_FRAME_PIXELS_DEF = 4096;

    // register widths and reset values
    localparam int FRAME_PIXELS_W   = 13;
    localparam int LOOP_DEPTH_W     = 8;
    localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RST = 13'd4096;
    localparam logic [LOOP_DEPTH_W-1:0]   LOOP_DEPTH_RST   = 8'd125;

    // register word index, taken from paddr[2]
    localparam logic REG_FRAME_PIXELS = 1'b0;
    localparam logic REG_LOOP_DEPTH   = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int PIXEL_W = 32;
    localparam logic [PIXEL_W-1:0] BLACK_PIXEL = '0;

    // output buffer
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic               is_recording;
        logic [PIXEL_W-1:0] pixel;
    } vfl_result_t;

    typedef struct packed {
        logic                  empty;
        logic [FIFO_CNT_W-1:0] level;
    } vfl_fifo_status_t;

endpackage

FILE: hdl/vfl_out_fifo.sv
module vfl_out_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  vfl_pkg::vfl_result_t      push_data,
    input  logic                      pop,
    output vfl_pkg::vfl_result_t      head_data,
    output vfl_pkg::vfl_fifo_status_t status
);
    import vfl_pkg::*;

    vfl_result_t           fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] level_reg, level_next;
    logic                  do_pop;

    assign do_pop = pop && (level_reg != '0);

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push && do_pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data    = fifo_mem[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.empty = (level_reg == '0);

endmodule

FILE: hdl/video_frame_looper_core.sv
// path: an input is registered in the store stage (store read), then in the output buffer
// throughput: one pixel per cycle while s_tready holds; at most one store write or read per pixel
// s_tready depends on registers only; a four-entry output buffer keeps the flow going under stalls
// reset: aresetn is synchronous, active low; control state and registers return to defaults
// the frame store is not cleared; a played entry that the take did not write holds stale contents
module video_frame_looper_core #(
    parameter int MAX_FRAMES       = vfl_pkg::MAX_FRAMES_DEF,
    parameter int MAX_FRAME_PIXELS = vfl_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input pixel stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vfl_pkg::PIXEL_W-1:0]     s_tdata,   // pixel_in
    input  logic [2:0]                      s_tuser,   // frame_start, punch_in, punch_out
    // output pixel stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vfl_pkg::PIXEL_W-1:0]     m_tdata,   // pixel_out
    output logic [0:0]                      m_tuser,   // is_recording
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vfl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [vfl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [vfl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import vfl_pkg::*;

    // slot number, loop length, store pixel offset, pixel counter
    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int LF_W   = $clog2(MAX_FRAMES + 1);
    localparam int PIX_W  = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
    localparam int IDX_W  = $clog2(MAX_FRAME_PIXELS + 1);
    // compare widths for clamping the registers
    localparam int FPC_W  = (IDX_W > FRAME_PIXELS_W) ? IDX_W : FRAME_PIXELS_W;
    localparam int DC_W   = (LF_W > LOOP_DEPTH_W) ? LF_W : LOOP_DEPTH_W;
    localparam int ADDR_W = SLOT_W + PIX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // ------------------------------------------------------------------
    // register port: word index in paddr[2], byte offset bits ignored
    // ------------------------------------------------------------------
    logic [FRAME_PIXELS_W-1:0] frame_pixels_reg;
    logic [LOOP_DEPTH_W-1:0]   loop_depth_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= FRAME_PIXELS_RST;
            loop_depth_reg   <= LOOP_DEPTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_PIXELS: frame_pixels_reg <= pwdata[FRAME_PIXELS_W-1:0];
                REG_LOOP_DEPTH:   loop_depth_reg   <= pwdata[LOOP_DEPTH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_PIXELS: prdata = APB_DATA_W'(frame_pixels_reg);
            REG_LOOP_DEPTH:   prdata = APB_DATA_W'(loop_depth_reg);
            default:          prdata = '0;
        endcase
    end

    // clamped frame length (1..MAX_FRAME_PIXELS) and loop depth (0..MAX_FRAMES)
    logic [FPC_W-1:0] fp_wide;
    logic [IDX_W-1:0] fp_eff;
    logic [DC_W-1:0]  depth_wide;
    logic [LF_W-1:0]  depth_eff;

    always_comb begin
        fp_wide = FPC_W'(frame_pixels_reg);
        if (fp_wide == '0) begin
            fp_eff = IDX_W'(1);
        end else if (fp_wide > FPC_W'(MAX_FRAME_PIXELS)) begin
            fp_eff = IDX_W'(MAX_FRAME_PIXELS);
        end else begin
            fp_eff = fp_wide[IDX_W-1:0];
        end
        depth_wide = DC_W'(loop_depth_reg);
        if (depth_wide > DC_W'(MAX_FRAMES)) begin
            depth_eff = LF_W'(MAX_FRAMES);
        end else begin
            depth_eff = depth_wide[LF_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // frame control state, updated on every accepted pixel
    // ------------------------------------------------------------------
    logic s_accept;
    logic frame_start, punch_in, punch_out;

    assign s_accept    = s_tvalid && s_tready;
    assign frame_start = s_tuser[0];
    assign punch_in    = s_tuser[1];
    assign punch_out   = s_tuser[2];

    logic              recording_reg, recording_next;
    logic              frame_rec_reg, frame_rec_next;
    logic [LF_W-1:0]   loop_frames_reg, loop_frames_next;
    logic [SLOT_W-1:0] play_pos_reg, play_pos_next;
    logic [SLOT_W-1:0] newest_slot_reg, newest_slot_next;   // slot last written to
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [IDX_W-1:0]  pixel_idx_reg, pixel_idx_next;

    logic              rec_t;
    logic [LF_W-1:0]   lf_t;
    logic [LF_W-1:0]   pp_inc;
    logic [LF_W-1:0]   back;
    logic [SLOT_W:0]   slot_sum;
    logic              idx_in_frame;

    always_comb begin
        recording_next   = recording_reg;
        frame_rec_next   = frame_rec_reg;
        loop_frames_next = loop_frames_reg;
        play_pos_next    = play_pos_reg;
        newest_slot_next = newest_slot_reg;
        read_slot_next   = read_slot_reg;
        pixel_idx_next   = pixel_idx_reg;
        rec_t    = recording_reg;
        lf_t     = loop_frames_reg;
        pp_inc   = LF_W'(play_pos_reg) + 1'b1;
        back     = '0;
        slot_sum = '0;

        if (frame_start) begin
            pixel_idx_next = '0;
            // punch-in: start over with an empty loop
            if (punch_in) begin
                rec_t = 1'b1;
                lf_t  = '0;
            end
            recording_next   = rec_t;
            frame_rec_next   = rec_t;
            loop_frames_next = lf_t;
            if (rec_t) begin
                // record into the next ring slot, loop grows up to the depth
                newest_slot_next = (newest_slot_reg == SLOT_W'(MAX_FRAMES - 1))
                                   ? '0 : newest_slot_reg + 1'b1;
                loop_frames_next = (lf_t >= depth_eff) ? depth_eff : lf_t + 1'b1;
                if (punch_out) begin
                    recording_next = 1'b0;
                    play_pos_next  = '0;
                end
            end else if (lf_t != '0) begin
                // step the play position, oldest frame first
                play_pos_next  = (pp_inc == lf_t) ? '0 : pp_inc[SLOT_W-1:0];
                back           = lf_t - 1'b1 - LF_W'(play_pos_next);
                if ((SLOT_W+1)'(newest_slot_reg) >= (SLOT_W+1)'(back)) begin
                    slot_sum = (SLOT_W+1)'(newest_slot_reg) - (SLOT_W+1)'(back);
                end else begin
                    slot_sum = (SLOT_W+1)'(newest_slot_reg) + (SLOT_W+1)'(MAX_FRAMES)
                               - (SLOT_W+1)'(back);
                end
                read_slot_next = slot_sum[SLOT_W-1:0];
            end
        end else if (pixel_idx_reg < fp_eff) begin
            pixel_idx_next = pixel_idx_reg + 1'b1;
        end
    end

    assign idx_in_frame = (pixel_idx_next < fp_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recording_reg   <= 1'b1;
            frame_rec_reg   <= 1'b1;
            loop_frames_reg <= '0;
            play_pos_reg    <= '0;
            newest_slot_reg <= SLOT_W'(MAX_FRAMES - 1);
            read_slot_reg   <= '0;
            pixel_idx_reg   <= '0;
        end else if (s_accept) begin
            recording_reg   <= recording_next;
            frame_rec_reg   <= frame_rec_next;
            loop_frames_reg <= loop_frames_next;
            play_pos_reg    <= play_pos_next;
            newest_slot_reg <= newest_slot_next;
            read_slot_reg   <= read_slot_next;
            pixel_idx_reg   <= pixel_idx_next;
        end
    end

    // ------------------------------------------------------------------
    // frame store: at most one write or one read per pixel, registered read data
    // a recorded pixel only writes, a played pixel only reads, so the two
    // never meet on one edge
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] frame_store_mem [MEM_DEPTH];
    logic [PIXEL_W-1:0] store_rd_reg;
    logic               mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0]  mem_wr_addr, mem_rd_addr;

    assign mem_wr_en   = s_accept && frame_rec_next && idx_in_frame;
    assign mem_rd_en   = s_accept && !frame_rec_next && idx_in_frame
                         && (loop_frames_next != '0);
    assign mem_wr_addr = {newest_slot_next, pixel_idx_next[PIX_W-1:0]};
    assign mem_rd_addr = {read_slot_next, pixel_idx_next[PIX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            frame_store_mem[mem_wr_addr] <= s_tdata;
        end
        if (mem_rd_en) begin
            store_rd_reg <= frame_store_mem[mem_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // store stage: pass-through pixel and selection, held next to the read
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic               s1_rec_reg;
    logic               s1_from_store_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_rec_reg        <= frame_rec_next;
            s1_from_store_reg <= mem_rd_en;
            s1_pixel_reg      <= s_tdata;
        end
    end

    vfl_result_t s1_result;

    always_comb begin
        s1_result.is_recording = s1_rec_reg;
        if (s1_rec_reg) begin
            s1_result.pixel = s1_pixel_reg;
        end else if (s1_from_store_reg) begin
            s1_result.pixel = store_rd_reg;
        end else begin
            s1_result.pixel = BLACK_PIXEL;
        end
    end

    // ------------------------------------------------------------------
    // output buffer; input side takes a transfer whenever the buffer has
    // room for every pixel already in flight
    // ------------------------------------------------------------------
    vfl_result_t      head_data;
    vfl_fifo_status_t fifo_status;
    logic [FIFO_CNT_W-1:0] in_flight;

    vfl_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_data (s1_result),
        .pop       (m_tready),
        .head_data (head_data),
        .status    (fifo_status)
    );

    assign in_flight = fifo_status.level + FIFO_CNT_W'(s1_valid_reg);
    assign s_tready  = (in_flight < FIFO_CNT_W'(FIFO_DEPTH));
    assign m_tvalid  = !fifo_status.empty;
    assign m_tdata   = head_data.pixel;
    assign m_tuser   = head_data.is_recording;

`ifndef SYNTHESIS
    // a pixel either records or plays, never both
    a_store_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en))
        else $error("frame store written and read on one edge");

    // the buffer always has room for the pixel leaving the store stage
    a_fifo_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (fifo_status.level != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("output buffer overrun");

    // an accepted pixel reaches the store stage next cycle
    a_stage_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted pixel lost before store stage");

    // during playback the position stays inside the loop
    a_play_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (!recording_reg && (loop_frames_reg != '0))
            |-> (LF_W'(play_pos_reg) < loop_frames_reg))
        else $error("play position outside loop");
`endif

endmodule

FILE: dv/video_frame_looper_core_tb.sv
`timescale 1ns / 1ps

module video_frame_looper_core_tb;
    import vfl_pkg::*;

    localparam int NUM_SLOTS   = MAX_FRAMES_DEF;
    localparam int SLOT_PIXELS = MAX_FRAME_PIXELS_DEF;
    // cycles without any transfer on either stream before the run is abandoned
    localparam int STALL_LIMIT = 1000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata;   // pixel_in
    logic [2:0]            s_tuser;   // frame_start, punch_in, punch_out
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIXEL_W-1:0]    m_tdata;   // pixel_out
    logic [0:0]            m_tuser;   // is_recording
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    video_frame_looper_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // looper prediction: control state, register copies and frame store
    // ------------------------------------------------------------------
    logic [FRAME_PIXELS_W-1:0] cfg_frame_px;
    logic [LOOP_DEPTH_W-1:0]   cfg_depth;
    logic                      armed_rec;    // next frame gets recorded
    logic                      frame_rec;    // mode of the frame in progress
    logic [7:0]                loop_len;
    logic [6:0]                replay_pos;
    logic [6:0]                wr_slot;
    logic [6:0]                rd_slot;
    logic [12:0]               px_idx;       // saturates at the frame size, may reach 4096
    logic [PIXEL_W-1:0]        stored_px [int unsigned];

    vfl_result_t pending_pixels [$];
    vfl_result_t new_res;
    vfl_result_t want_res;

    int  fail_count   = 0;
    int  stall_cycles = 0;
    bit  calm         = 1'b0;   // no idling on either side while set

    // register value clamped to the range the block honours
    function automatic int eff_frame_px();
        if (cfg_frame_px == 0) return 1;
        if (cfg_frame_px > SLOT_PIXELS) return SLOT_PIXELS;
        return int'(cfg_frame_px);
    endfunction

    function automatic void predict_looper_pixel(input logic [PIXEL_W-1:0] px,
                                                 input logic [2:0] flags,
                                                 output vfl_result_t res);
        int          fp;
        int          depth;
        int          back;
        logic [6:0]  newest;
        logic [18:0] key;
        fp    = eff_frame_px();
        depth = (cfg_depth > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_depth);
        if (flags[0]) begin
            px_idx = '0;
            if (flags[1]) begin
                armed_rec = 1'b1;
                loop_len  = '0;
            end
            frame_rec = armed_rec;
            if (armed_rec) begin
                wr_slot  = wr_slot + 7'd1;
                loop_len = (int'(loop_len) + 1 > depth) ? 8'(depth) : loop_len + 8'd1;
                if (flags[2]) begin
                    armed_rec  = 1'b0;
                    replay_pos = '0;
                end
            end else if (loop_len != 0) begin
                // step round the loop, oldest kept frame first after the newest
                replay_pos = 7'((int'(replay_pos) + 1) % int'(loop_len));
                back       = (int'(loop_len) - 1 - int'(replay_pos)) % NUM_SLOTS;
                rd_slot    = 7'(int'(wr_slot) - 1 - back);
            end
        end else if (px_idx < fp) begin
            px_idx = px_idx + 13'd1;
        end

        newest           = wr_slot - 7'd1;
        res.is_recording = frame_rec;
        if (frame_rec) begin
            if (px_idx < fp) begin
                key = {newest, px_idx[11:0]};
                stored_px[key] = px;
            end
            res.pixel = px;
        end else if (loop_len == 0 || px_idx >= fp) begin
            res.pixel = BLACK_PIXEL;
        end else begin
            key = {rd_slot, px_idx[11:0]};
            res.pixel = stored_px.exists(key) ? stored_px[key] : BLACK_PIXEL;
        end
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // monitor: predict on each input transfer, check each output transfer
    // both sampled on the rising edge, inputs having been driven on the falling one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_looper_pixel(s_tdata, s_tuser, new_res);
                pending_pixels.push_back(new_res);
            end
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("unrequested result", 'x, m_tdata);
                end else begin
                    want_res = pending_pixels.pop_front();
                    if (m_tdata !== want_res.pixel)
                        report_mismatch("pixel_out", want_res.pixel, m_tdata);
                    if (m_tuser[0] !== want_res.is_recording)
                        report_mismatch("is_recording", 32'(want_res.is_recording),
                                        32'(m_tuser[0]));
                end
            end
            // watchdog on transfers of either stream
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver back-pressure, about a third of cycles unless calm
    always @(negedge aclk) begin
        m_tready = calm || ($urandom_range(99) >= 33);
    end

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic fs,
                              input logic pin, input logic pout);
        bit rdy;
        if (!calm && $urandom_range(99) < 25) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        s_tuser  = {pout, pin, fs};
        // s_tready comes from flops, so its value here holds up to the next edge
        do begin
            rdy = s_tready;
            @(posedge aclk);
            @(negedge aclk);
        end while (!rdy);
    endtask

    // one frame: flags on the first pixel, stray punch bits on the rest
    task automatic send_frame(input int len, input logic pin, input logic pout);
        logic [PIXEL_W-1:0] px;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0:       px = '0;
                1:       px = '1;
                default: px = $urandom;
            endcase
            if (i == 0)
                send_pixel(px, 1'b1, pin, pout);
            else
                send_pixel(px, 1'b0, $urandom_range(99) < 15, $urandom_range(99) < 15);
        end
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
    endtask

    // apb write, then read back the same register
    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] rd;
        mask = (idx == REG_FRAME_PIXELS) ? (32'd1 << FRAME_PIXELS_W) - 1
                                         : (32'd1 << LOOP_DEPTH_W) - 1;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        if (idx == REG_FRAME_PIXELS)
            cfg_frame_px = val[FRAME_PIXELS_W-1:0];
        else
            cfg_depth = val[LOOP_DEPTH_W-1:0];

        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if ((rd & mask) !== (val & mask))
            report_mismatch("register readback", val & mask, rd & mask);
    endtask

    // only with the block idle: nothing in flight, no input offered
    task automatic apply_settings(input logic [APB_DATA_W-1:0] fp_val,
                                  input logic [APB_DATA_W-1:0] depth_val);
        drain_results();
        write_reg(REG_FRAME_PIXELS, fp_val);
        write_reg(REG_LOOP_DEPTH, depth_val);
    endtask

    // record / play session with random content; starts with a punch-in.
    // recorded frames always carry at least a full frame, so playback never
    // reaches a store entry that was not written
    task automatic run_loop_session(input int n_items, input int min_take,
                                    input int pout_pct, input int pin_pct);
        int   sent;
        int   take;
        int   len;
        int   fp;
        logic pin;
        logic pout;
        logic rec;
        sent = 0;
        take = 0;
        fp   = eff_frame_px();
        while (sent < n_items) begin
            pin = (sent == 0) || ($urandom_range(99) < pin_pct);
            if (pin)
                take = 0;
            rec = pin || armed_rec;
            if (rec) begin
                take++;
                len  = fp + $urandom_range(0, 2);
                pout = (take >= min_take) && ($urandom_range(99) < pout_pct);
            end else begin
                // punch-out while playing is ignored by the block
                pout = ($urandom_range(99) < 10);
                case ($urandom_range(9))
                    0:       len = $urandom_range(1, fp);
                    1:       len = fp + $urandom_range(1, 3);
                    default: len = fp;
                endcase
            end
            send_frame(len, pin, pout);
            sent += len;
            if ($urandom_range(99) < 3)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // pixels before the first frame start count as a recording frame;
    // punch bits away from a frame start have no effect
    task automatic test_prestart_pixels();
        send_pixel(32'h0000_0000, 1'b0, 1'b1, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        drain_results();
    endtask

    // short frames: record three, punch out, replay, run past the frame end
    task automatic test_directed_loop();
        apply_settings(32'd4, 32'd3);
        send_pixel(32'h0000_0000, 1'b1, 1'b1, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_pixel(32'hA5A5_A5A5, 1'b0, 1'b1, 1'b1);
        send_pixel(32'h5A5A_5A5A, 1'b0, 1'b0, 1'b0);
        send_frame(5, 1'b0, 1'b0);   // one pixel past the end, not stored
        send_frame(4, 1'b0, 1'b1);   // last recorded frame
        send_frame(4, 1'b0, 1'b0);
        send_frame(5, 1'b0, 1'b1);   // playing: punch-out ignored, last pixel black
        send_frame(2, 1'b0, 1'b0);   // short played frame
    endtask

    // out-of-range register values, empty loop, single-frame loop
    task automatic test_register_extremes();
        apply_settings(32'd0, 32'd1);     // frame size clamps to one pixel
        run_loop_session(120, 1, 40, 10);
        apply_settings(32'd4, 32'd0);     // empty loop, playback is black
        run_loop_session(150, 1, 40, 10);
        apply_settings(32'd7, 32'd255);   // depth clamps to the slot count
        run_loop_session(300, 5, 25, 8);
        apply_settings(32'd3, 32'd2);
        run_loop_session(200, 1, 30, 10);
    endtask

    // long take past the ring size with no idling on either side
    task automatic test_long_take();
        apply_settings(32'd1, 32'd128);
        calm = 1'b1;
        run_loop_session(420, 140, 30, 1);
        drain_results();
        calm = 1'b0;
    endtask

    // frame size above the slot size clamps; a short take replayed in part
    task automatic test_frame_size_clamp();
        apply_settings(32'd8191, 32'd1);
        send_frame(40, 1'b1, 1'b1);
        send_frame(20, 1'b0, 1'b0);
        send_frame(3, 1'b0, 1'b0);
    endtask

    task automatic test_random_settings();
        logic [APB_DATA_W-1:0] fp_val;
        logic [APB_DATA_W-1:0] depth_val;
        for (int p = 0; p < 4; p++) begin
            fp_val    = $urandom_range(1, 12);
            depth_val = ($urandom_range(3) == 0) ? $urandom_range(129, 255)
                                                 : $urandom_range(0, 128);
            apply_settings(fp_val, depth_val);
            run_loop_session(175, $urandom_range(1, 6), 30, 8);
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        // prediction starts from the reset state
        cfg_frame_px = FRAME_PIXELS_RST;
        cfg_depth    = LOOP_DEPTH_RST;
        armed_rec    = 1'b1;
        frame_rec    = 1'b1;
        loop_len     = '0;
        replay_pos   = '0;
        wr_slot      = '0;
        rd_slot      = '0;
        px_idx       = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_prestart_pixels();
        test_directed_loop();
        test_register_extremes();
        test_long_take();
        test_frame_size_clamp();
        test_random_settings();

        // let the output buffer empty, then watch for stray transfers
        drain_results();
        repeat (16) @(posedge aclk);
        if (fail_count == 0 && pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/vfl_pkg.sv
hdl/vfl_out_fifo.sv
hdl/video_frame_looper_core.sv
dv/video_frame_looper_core_tb.sv
